>>> hw/rtl/eeg_pkg.sv
// ----------------------------------------------------------------------------
// Extended Euclidean GCD - shared package
// Field widths, parameter defaults and the command/status bundles that pass
// between the controller and the datapath.
// ----------------------------------------------------------------------------
package eeg_pkg;

	localparam int OPND_W    = 31;  // operand and divisor width
	localparam int COEF_W    = 32;  // coefficient field width on the port
	localparam int SHIFT_W   = 5;   // divisor alignment count, up to OPND_W - 1
	localparam int WIDTH_DEF = 32;  // default coefficient arithmetic width

	localparam int IN_TDATA_W  = 64;  // 2 * OPND_W rounded up to bytes
	localparam int OUT_TDATA_W = 96;  // OPND_W + 2 * COEF_W rounded up to bytes

	// Commands from the controller, one per datapath action
	typedef struct packed {
		logic load;    // take a new operand pair, set the coefficient matrix to identity
		logic start;   // begin a remainder step: divisor <- a, remainder <- b
		logic shift;   // align the divisor one bit further left
		logic step;    // one restoring-division bit, quotient folded into accumulators
		logic update;  // fold the finished quotient into the coefficient matrix
		logic finish;  // copy gcd and coefficients into the result register
	} eeg_cmd_t;

	// Status back to the controller
	typedef struct packed {
		logic a_zero;      // first operand has reached zero
		logic align_more;  // divisor doubled still fits under the remainder
		logic last_bit;    // current division bit is the least significant one
	} eeg_sts_t;

endpackage

>>> hw/rtl/extended_euclid_gcd_unit.sv
// ----------------------------------------------------------------------------
// Extended Euclidean GCD unit
// Returns gcd(a, b) and Bezout coefficients x, y with a*x + b*y = gcd.
//
//   channel  dir  tdata bits (lowest first)                         tlast tuser
//   s_       in   operand_a[30:0], operand_b[61:31], zero [63:62]    -     -
//   m_       out  divisor[30:0], coef_a[62:31], coef_b[94:63], 0[95] -     -
//
// One operand pair at a time. Each remainder step of the Euclidean descent
// aligns the divisor under the dividend, then runs the one-bit-per-cycle
// shift-subtract divider over s, the bit distance between the two. The time
// a pair takes grows with its steps and their s; when a is zero the result
// is written with no remainder step.
// The result register frees the unit to take the next pair while a result
// waits; a stalled result holds the unit only when the next one is ready.
// Reset is asynchronous and clears only control state.
// ----------------------------------------------------------------------------
module extended_euclid_gcd_unit #(
	parameter int WIDTH = eeg_pkg::WIDTH_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	output logic                             s_tready,
	input  logic [eeg_pkg::IN_TDATA_W-1:0]   s_tdata,   // operand_a, operand_b
	output logic                             m_tvalid,
	input  logic                             m_tready,
	output logic [eeg_pkg::OUT_TDATA_W-1:0]  m_tdata    // divisor, coef_a, coef_b
);
	import eeg_pkg::*;

	eeg_cmd_t          cmd;
	eeg_sts_t          sts;
	logic [OPND_W-1:0] divisor;
	logic [COEF_W-1:0] coef_a, coef_b;

	eeg_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	eeg_datapath #(
		.WIDTH (WIDTH)
	) u_datapath (
		.clk       (clk),
		.cmd       (cmd),
		.sts       (sts),
		.operand_a (s_tdata[OPND_W-1:0]),
		.operand_b (s_tdata[2*OPND_W-1:OPND_W]),
		.divisor   (divisor),
		.coef_a    (coef_a),
		.coef_b    (coef_b)
	);

	assign m_tdata = {{(OUT_TDATA_W-OPND_W-2*COEF_W){1'b0}}, coef_b, coef_a, divisor};

endmodule

>>> hw/rtl/eeg_datapath.sv
// ----------------------------------------------------------------------------
// Extended Euclidean GCD - datapath
// Shift-subtract divider for one remainder step, shift-add accumulation of
// quotient times coefficient, the 2x2 coefficient matrix and the result
// register.
// ----------------------------------------------------------------------------
module eeg_datapath #(
	parameter int WIDTH = eeg_pkg::WIDTH_DEF
) (
	input  logic                        clk,
	input  eeg_pkg::eeg_cmd_t           cmd,
	output eeg_pkg::eeg_sts_t           sts,
	input  logic [eeg_pkg::OPND_W-1:0]  operand_a,
	input  logic [eeg_pkg::OPND_W-1:0]  operand_b,
	output logic [eeg_pkg::OPND_W-1:0]  divisor,
	output logic [eeg_pkg::COEF_W-1:0]  coef_a,
	output logic [eeg_pkg::COEF_W-1:0]  coef_b
);
	import eeg_pkg::*;

	logic [OPND_W-1:0]  a_q, b_q, r_q;
	logic [OPND_W:0]    d_q;
	logic [SHIFT_W-1:0] s_q;
	logic [WIDTH-1:0]   acc0_q, acc1_q;
	logic [WIDTH-1:0]   p00_q, p01_q, p10_q, p11_q;

	logic [OPND_W:0]    r_ext, diff;
	logic               ge;
	logic [OPND_W-1:0]  r_next;
	logic [WIDTH-1:0]   acc0_next, acc1_next;
	logic [COEF_W-1:0]  x_ext, y_ext;

	assign r_ext  = {1'b0, r_q};
	assign ge     = r_ext >= d_q;
	assign diff   = r_ext - d_q;
	assign r_next = ge ? diff[OPND_W-1:0] : r_q;

	// Quotient bits arrive MSB first: acc = 2*acc + bit*p gives q*p mod 2^WIDTH
	assign acc0_next = {acc0_q[WIDTH-2:0], 1'b0} + (ge ? p00_q : '0);
	assign acc1_next = {acc1_q[WIDTH-2:0], 1'b0} + (ge ? p10_q : '0);

	assign sts.a_zero     = (a_q == '0);
	assign sts.align_more = {d_q[OPND_W-1:0], 1'b0} <= r_ext;
	assign sts.last_bit   = (s_q == '0);

	// Sign-extend or truncate the coefficients to the port width
	generate
		if (WIDTH >= COEF_W) begin : g_trunc
			assign x_ext = p01_q[COEF_W-1:0];
			assign y_ext = p11_q[COEF_W-1:0];
		end else begin : g_sext
			assign x_ext = {{(COEF_W-WIDTH){p01_q[WIDTH-1]}}, p01_q};
			assign y_ext = {{(COEF_W-WIDTH){p11_q[WIDTH-1]}}, p11_q};
		end
	endgenerate

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			a_q   <= operand_a;
			b_q   <= operand_b;
			p00_q <= WIDTH'(1);
			p01_q <= '0;
			p10_q <= '0;
			p11_q <= WIDTH'(1);
		end
		if (cmd.start) begin
			d_q    <= {1'b0, a_q};
			r_q    <= b_q;
			s_q    <= '0;
			acc0_q <= '0;
			acc1_q <= '0;
		end
		if (cmd.shift) begin
			d_q <= {d_q[OPND_W-1:0], 1'b0};
			s_q <= s_q + SHIFT_W'(1);
		end
		if (cmd.step) begin
			r_q    <= r_next;
			acc0_q <= acc0_next;
			acc1_q <= acc1_next;
			d_q    <= d_q >> 1;
			s_q    <= s_q - SHIFT_W'(1);
			// last bit: the remainder is final, advance the operand pair
			if (sts.last_bit) begin
				a_q <= r_next;
				b_q <= a_q;
			end
		end
		if (cmd.update) begin
			// P <- P * [[-q, 1], [1, 0]]
			p00_q <= p01_q - acc0_q;
			p01_q <= p00_q;
			p10_q <= p11_q - acc1_q;
			p11_q <= p10_q;
		end
		if (cmd.finish) begin
			divisor <= b_q;
			coef_a  <= x_ext;
			coef_b  <= y_ext;
		end
	end

endmodule

>>> hw/rtl/eeg_ctrl.sv
// ----------------------------------------------------------------------------
// Extended Euclidean GCD - controller
// Sequences load, remainder steps (align, divide, update) and result hand-off,
// and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module eeg_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	output logic               m_tvalid,
	input  logic               m_tready,
	input  eeg_pkg::eeg_sts_t  sts,
	output eeg_pkg::eeg_cmd_t  cmd
);
	import eeg_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CHECK,
		ST_ALIGN,
		ST_DIV,
		ST_UPDATE
	} state_t;

	state_t state_q;
	logic   out_valid_q;
	logic   out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	always_comb begin
		cmd = '0;
		case (state_q)
			ST_IDLE:   cmd.load = s_tvalid;
			ST_CHECK: begin
				if (sts.a_zero) begin
					cmd.finish = out_free;
				end else begin
					cmd.start = 1'b1;
				end
			end
			ST_ALIGN:  cmd.shift  = sts.align_more;
			ST_DIV:    cmd.step   = 1'b1;
			ST_UPDATE: cmd.update = 1'b1;
			default:   cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			// hold the result until taken; a new one may land the same cycle
			if (cmd.finish) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (s_tvalid) begin
						state_q <= ST_CHECK;
					end
				end
				ST_CHECK: begin
					if (!sts.a_zero) begin
						state_q <= ST_ALIGN;
					end else if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_ALIGN: begin
					if (!sts.align_more) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (sts.last_bit) begin
						state_q <= ST_UPDATE;
					end
				end
				ST_UPDATE: state_q <= ST_CHECK;
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> tb/testbench.sv
// ----------------------------------------------------------------------------
// Extended Euclidean GCD unit - self-checking testbench
// Drives operand pairs into the stream slave port and checks each result on
// the master port against a behavioural model of the recursive Bezout
// formulation. Directed corner pairs come first, then random pairs of mixed
// magnitude, random pairs with drained pauses, pairs with a forced common
// factor, and a final stream with no idling on either side.
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import eeg_pkg::*;

	localparam int GCD_WIDTH = WIDTH_DEF;
	localparam logic [OPND_W-1:0] OPND_MAX = '1;
	localparam int DRAIN_CYCLES = 400;  // worst pair: ~45 remainder steps plus alignment

	typedef struct packed {
		logic [OPND_W-1:0] divisor;
		logic [COEF_W-1:0] coef_a;
		logic [COEF_W-1:0] coef_b;
	} gcd_result_t;

	logic                   clk;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;   // operand_a, operand_b
	logic                   m_tvalid;
	logic                   m_tready;
	logic [OUT_TDATA_W-1:0] m_tdata;   // divisor, coef_a, coef_b

	gcd_result_t expected_results[$];
	int          pairs_sent;
	int          results_checked;
	int          mismatches;
	bit          gaps_on;
	bit          stalls_on;

	extended_euclid_gcd_unit #(
		.WIDTH(GCD_WIDTH)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#50ms;
		$display("FAIL extended_euclid_gcd_unit");
		$finish;
	end

	// Wrap to the arithmetic width, sign-extend, then cut to the port field
	function automatic logic [COEF_W-1:0] wrap_coef(input longint unsigned v,
			input longint unsigned mask);
		longint unsigned w;
		w = v & mask;
		if (w[GCD_WIDTH-1])
			w = w | ~mask;
		return w[COEF_W-1:0];
	endfunction

	function automatic gcd_result_t predict_gcd(input logic [OPND_W-1:0] opa,
			input logic [OPND_W-1:0] opb);
		longint unsigned a;
		longint unsigned b;
		longint unsigned r;
		longint unsigned x;
		longint unsigned y;
		longint unsigned nx;
		longint unsigned mask;
		longint unsigned quotients[$];
		gcd_result_t     res;
		mask = (GCD_WIDTH >= 64) ? '1 : ((64'd1 << GCD_WIDTH) - 64'd1);
		a = opa;
		b = opb;
		// descend, keeping every quotient
		while (a != 0) begin
			quotients.push_back(b / a);
			r = b % a;
			b = a;
			a = r;
		end
		// unwind from the base case (b, 0, 1)
		x = 0;
		y = 1;
		while (quotients.size() > 0) begin
			nx = (y - quotients.pop_back() * x) & mask;
			y = x;
			x = nx;
		end
		res.divisor = b[OPND_W-1:0];
		res.coef_a  = wrap_coef(x, mask);
		res.coef_b  = wrap_coef(y, mask);
		return res;
	endfunction

	// Operand of random magnitude: full range, short, zero or near the top
	function automatic logic [OPND_W-1:0] random_operand();
		logic [31:0] raw;
		int unsigned kind;
		raw  = $urandom;
		kind = $urandom_range(0, 9);
		if (kind < 4)
			return raw[OPND_W-1:0];
		else if (kind < 8)
			return raw[OPND_W-1:0] >> $urandom_range(0, OPND_W - 1);
		else if (kind == 8)
			return '0;
		else
			return OPND_MAX - raw[3:0];
	endfunction

	task automatic send_pair(input logic [OPND_W-1:0] opa, input logic [OPND_W-1:0] opb);
		if (gaps_on && $urandom_range(0, 3) == 0) begin
			s_tvalid <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {{(IN_TDATA_W - 2 * OPND_W){1'b0}}, opb, opa};
		do @(posedge clk); while (!s_tready);
		expected_results.push_back(predict_gcd(opa, opb));
		pairs_sent++;
	endtask

	// Result receiver: random stall bursts between stretches of ready
	initial begin
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			if (stalls_on && $urandom_range(0, 2) == 0) begin
				m_tready <= 1'b0;
				repeat ($urandom_range(1, 7)) @(posedge clk);
			end
			m_tready <= 1'b1;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	end

	always @(posedge clk) begin
		gcd_result_t exp_res;
		gcd_result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.divisor = m_tdata[OPND_W-1:0];
			got.coef_a  = m_tdata[OPND_W +: COEF_W];
			got.coef_b  = m_tdata[OPND_W + COEF_W +: COEF_W];
			if (expected_results.size() == 0) begin
				$error("unexpected result transaction: divisor %0d", got.divisor);
				mismatches++;
			end else begin
				exp_res = expected_results.pop_front();
				results_checked++;
				if (got.divisor !== exp_res.divisor) begin
					$error("divisor: expected %0d, actual %0d", exp_res.divisor, got.divisor);
					mismatches++;
				end
				if (got.coef_a !== exp_res.coef_a) begin
					$error("coef_a: expected %0d, actual %0d",
						$signed(exp_res.coef_a), $signed(got.coef_a));
					mismatches++;
				end
				if (got.coef_b !== exp_res.coef_b) begin
					$error("coef_b: expected %0d, actual %0d",
						$signed(exp_res.coef_b), $signed(got.coef_b));
					mismatches++;
				end
			end
		end
	end

	task automatic test_corner_pairs();
		send_pair('0, '0);
		send_pair('0, 31'd12345);
		send_pair(31'd98765, '0);
		send_pair('0, OPND_MAX);
		send_pair(OPND_MAX, '0);
		send_pair(OPND_MAX, OPND_MAX);
		send_pair(31'd1, OPND_MAX);
		send_pair(OPND_MAX, 31'd1);
		send_pair(31'd1, 31'd1);
		send_pair(31'd1, '0);
		send_pair('0, 31'd1);
		send_pair(OPND_MAX, OPND_MAX - 31'd1);
		send_pair(OPND_MAX - 31'd1, OPND_MAX);
		// consecutive Fibonacci numbers: longest descent and largest coefficients
		send_pair(31'd1134903170, 31'd1836311903);
		send_pair(31'd1836311903, 31'd1134903170);
		send_pair(31'd701408733, 31'd1134903170);
		send_pair(31'd12345, 31'd12345);
		send_pair(31'h4000_0000, 31'h6000_0000);
		send_pair(31'd240, 31'd46);
		send_pair(31'h2AAA_AAAA, 31'h5555_5555);
		send_pair(31'd3, 31'h4000_0000);
	endtask

	task automatic test_random_operands(input int count);
		for (int i = 0; i < count; i++) begin
			// switch idling on and off in stretches
			if (i % 100 == 0) begin
				gaps_on   = ($urandom_range(0, 3) != 0);
				stalls_on = ($urandom_range(0, 3) != 0);
			end
			send_pair(random_operand(), random_operand());
		end
	endtask

	// Hold the sender back until every outstanding result has come home
	task automatic test_pause_until_idle(input int count);
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
		for (int i = 0; i < count; i++) begin
			send_pair(random_operand(), random_operand());
			if (i % 10 == 9) begin
				s_tvalid <= 1'b0;
				while (expected_results.size() != 0) @(posedge clk);
			end
		end
	endtask

	task automatic test_common_factor(input int count);
		int unsigned factor;
		int unsigned u;
		int unsigned v;
		for (int i = 0; i < count; i++) begin
			factor = $urandom_range(1, 65535) >> $urandom_range(0, 15);
			if (factor == 0)
				factor = 1;
			u = $urandom_range(0, OPND_MAX / factor);
			v = $urandom_range(0, OPND_MAX / factor);
			send_pair(OPND_W'(u * factor), OPND_W'(v * factor));
		end
	endtask

	task automatic test_quiet_stream(input int count);
		gaps_on   = 1'b0;
		stalls_on = 1'b0;
		for (int i = 0; i < count; i++)
			send_pair(random_operand(), random_operand());
	endtask

	initial begin
		arst_n    = 1'b0;
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
		pairs_sent      = 0;
		results_checked = 0;
		mismatches      = 0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_corner_pairs();
		test_random_operands(1100);
		test_pause_until_idle(40);
		test_common_factor(450);
		test_quiet_stream(340);

		s_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Checked %0d results from %0d operand pairs: corners, mixed magnitudes,",
			results_checked, pairs_sent);
		$display("forced common factors, drained pauses and an unthrottled stream.");
		if (mismatches == 0)
			$display("PASS extended_euclid_gcd_unit");
		else
			$display("FAIL extended_euclid_gcd_unit");
		$finish;
	end

endmodule
